// ===== rtl/rbs_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Room booking scheduler package
// Shared payload types, field widths and default sizes.
// ----------------------------------------------------------------------------
package rbs_pkg;

	localparam int ROOMS_DEF = 16;
	localparam int TIME_W    = 32;
	localparam int BUSY_W    = 48;
	localparam int COUNT_W   = 32;
	localparam int ROOM_W    = 4;
	localparam int RCNT_W    = 5;

	localparam logic [RCNT_W-1:0] RCNT_RESET = RCNT_W'(16);

	localparam logic REQ_BOOK   = 1'b0;
	localparam logic REQ_REPORT = 1'b1;

	typedef struct packed {
		logic              req_type;
		logic [TIME_W-1:0] start_time;
		logic [TIME_W-1:0] stop_time;
	} req_t;

	typedef struct packed {
		logic              is_report;
		logic [ROOM_W-1:0] room;
		logic [BUSY_W-1:0] actual_begin;
		logic [BUSY_W-1:0] actual_finish;
		logic              none_booked;
	} res_t;

endpackage : rbs_pkg
`default_nettype wire

// ===== rtl/rbs_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module rbs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule : rbs_ram
`default_nettype wire

// ===== rtl/room_booking_scheduler.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Room booking scheduler
// Greedy room assignment: a booking takes the lowest free room, otherwise the
// room that frees earliest, and a report returns the most booked room.
//
// A request is transferred when start is high and busy is low. Busy stays high
// until the result is produced. The result appears on result for exactly one
// cycle with done high; the receiver cannot stall it, and busy is already low
// in that cycle, so the next request can be transferred alongside it.
// A booking scans the first n rooms, n being the room count clamped to 1..ROOMS;
// a report scans all ROOMS rooms. The busy-until and count memories are read one
// room per cycle through single read ports, then a done step writes a booking.
// Write the room count register through cfg_valid/cfg_ready only while idle;
// the block itself does not enforce it. Reset clears the control state, a valid
// bit per room and the room count (back to 16). Rooms never written read as
// zero, so no clearing pass is run.
// ----------------------------------------------------------------------------
module room_booking_scheduler #(
	parameter int ROOMS = rbs_pkg::ROOMS_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	output logic                            busy,
	input  wire rbs_pkg::req_t              req,
	output logic                            done,
	output rbs_pkg::res_t                   result,
	input  wire logic                       cfg_valid,
	output logic                            cfg_ready,
	input  wire logic [rbs_pkg::RCNT_W-1:0] cfg_data
);

	localparam int IW = (ROOMS > 1) ? $clog2(ROOMS) : 1;
	localparam int CW = $clog2(ROOMS + 1);
	localparam int BW = rbs_pkg::BUSY_W;
	localparam int NW = rbs_pkg::COUNT_W;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	logic [1:0]                   state_q;
	logic [rbs_pkg::RCNT_W-1:0]   room_count_q;
	logic [ROOMS-1:0]             vld_q;
	logic                         any_booked_q;
	logic                         is_rep_q;
	logic [rbs_pkg::TIME_W-1:0]   start_q;
	logic [rbs_pkg::TIME_W-1:0]   dur_q;
	logic [CW-1:0]                limit_q;
	logic [CW-1:0]                iss_q;
	logic                         val_s1;
	logic [IW-1:0]                idx_s1;
	logic                         found_q;
	logic [IW-1:0]                free_idx_q;
	logic [NW-1:0]                free_cnt_q;
	logic [IW-1:0]                min_idx_q;
	logic [BW-1:0]                min_val_q;
	logic [NW-1:0]                min_cnt_q;
	logic [IW-1:0]                best_idx_q;
	logic [NW-1:0]                best_cnt_q;
	logic                         done_q;
	rbs_pkg::res_t                res_q;

	logic          accept;
	logic          issue;
	logic          last_s1;
	logic [CW-1:0] limit_d;
	logic [BW-1:0] busy_rd;
	logic [NW-1:0] cnt_rd;
	logic [BW-1:0] busy_val;
	logic [NW-1:0] cnt_val;
	logic [IW-1:0] sel_idx;
	logic [NW-1:0] sel_cnt;
	logic [NW-1:0] new_cnt;
	logic [BW-1:0] begin_t;
	logic [BW:0]   sum_t;
	logic [BW-1:0] finish_t;
	logic          we;

	assign busy      = (state_q != ST_IDLE);
	assign accept    = start && !busy;
	assign cfg_ready = 1'b1;
	assign done      = done_q;
	assign result    = res_q;

	always_comb begin
		if (room_count_q == '0) begin
			limit_d = CW'(1);
		end else if (int'(room_count_q) > ROOMS) begin
			limit_d = CW'(ROOMS);
		end else begin
			limit_d = CW'(room_count_q);
		end
	end

	assign issue   = (state_q == ST_SCAN) && (iss_q < limit_q);
	assign last_s1 = val_s1 && (iss_q == limit_q);

	assign busy_val = vld_q[idx_s1] ? busy_rd : '0;
	assign cnt_val  = vld_q[idx_s1] ? cnt_rd  : '0;

	assign sel_idx  = found_q ? free_idx_q : min_idx_q;
	assign sel_cnt  = found_q ? free_cnt_q : min_cnt_q;
	assign new_cnt  = (sel_cnt == '1) ? sel_cnt : sel_cnt + NW'(1);
	assign begin_t  = found_q ? BW'(start_q) : min_val_q;
	assign sum_t    = {1'b0, begin_t} + (BW + 1)'(dur_q);
	assign finish_t = sum_t[BW] ? '1 : sum_t[BW-1:0];
	assign we       = (state_q == ST_DONE) && !is_rep_q;

	rbs_ram #(
		.WIDTH (BW),
		.DEPTH (ROOMS),
		.AW    (IW)
	) u_busy_ram (
		.clk   (clk),
		.we    (we),
		.waddr (sel_idx),
		.wdata (finish_t),
		.re    (issue),
		.raddr (iss_q[IW-1:0]),
		.rdata (busy_rd)
	);

	rbs_ram #(
		.WIDTH (NW),
		.DEPTH (ROOMS),
		.AW    (IW)
	) u_count_ram (
		.clk   (clk),
		.we    (we),
		.waddr (sel_idx),
		.wdata (new_cnt),
		.re    (issue),
		.raddr (iss_q[IW-1:0]),
		.rdata (cnt_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			room_count_q <= rbs_pkg::RCNT_RESET;
			vld_q        <= '0;
			any_booked_q <= 1'b0;
			val_s1       <= 1'b0;
			done_q       <= 1'b0;
		end else begin
			done_q <= 1'b0;
			val_s1 <= issue;
			if (cfg_valid && cfg_ready) begin
				room_count_q <= cfg_data;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (last_s1) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					state_q <= ST_IDLE;
					done_q  <= 1'b1;
					if (!is_rep_q) begin
						vld_q[sel_idx] <= 1'b1;
						any_booked_q   <= 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			idx_s1 <= iss_q[IW-1:0];
			iss_q  <= iss_q + CW'(1);
		end
		if (accept) begin
			is_rep_q   <= (req.req_type == rbs_pkg::REQ_REPORT);
			start_q    <= req.start_time;
			dur_q      <= (req.stop_time > req.start_time) ?
				req.stop_time - req.start_time : '0;
			limit_q    <= (req.req_type == rbs_pkg::REQ_REPORT) ? CW'(ROOMS) : limit_d;
			iss_q      <= '0;
			found_q    <= 1'b0;
			best_idx_q <= '0;
			best_cnt_q <= '0;
		end
		if (val_s1) begin
			if (!found_q && (busy_val <= BW'(start_q))) begin
				found_q    <= 1'b1;
				free_idx_q <= idx_s1;
				free_cnt_q <= cnt_val;
			end
			if ((idx_s1 == '0) || (busy_val < min_val_q)) begin
				min_idx_q <= idx_s1;
				min_val_q <= busy_val;
				min_cnt_q <= cnt_val;
			end
			if (cnt_val > best_cnt_q) begin
				best_idx_q <= idx_s1;
				best_cnt_q <= cnt_val;
			end
		end
		if (state_q == ST_DONE) begin
			if (is_rep_q) begin
				res_q.is_report     <= 1'b1;
				res_q.room          <= rbs_pkg::ROOM_W'(best_idx_q);
				res_q.actual_begin  <= '0;
				res_q.actual_finish <= '0;
				res_q.none_booked   <= !any_booked_q;
			end else begin
				res_q.is_report     <= 1'b0;
				res_q.room          <= rbs_pkg::ROOM_W'(sel_idx);
				res_q.actual_begin  <= begin_t;
				res_q.actual_finish <= finish_t;
				res_q.none_booked   <= 1'b0;
			end
		end
	end

endmodule : room_booking_scheduler
`default_nettype wire
